// File: rtl/core/b2d_pkg.sv
// Package for the binary to decimal digit converter: defaults, widths and helpers.
`default_nettype none
package b2d_pkg;
	localparam int ValueBitsDefault = 64;
	localparam int MaxDigitsDefault = 20;
	localparam int ValueW           = 64;
	localparam int CharW            = 6;
	localparam logic [CharW-1:0] AsciiZero = 6'd48;

	// Add 3 to a BCD nibble of five or more ahead of the doubling shift
	function automatic logic [3:0] dabble_adj(input logic [3:0] nib);
		logic [3:0] r;
		r = (nib >= 4'd5) ? nib + 4'd3 : nib;
		return r;
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/b2d_in_if.sv
// Input channel: one unsigned binary value per item.
`default_nettype none
interface b2d_in_if;
	logic                          valid;
	logic                          ready;
	logic [b2d_pkg::ValueW-1:0]    value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

// File: rtl/core/b2d_out_if.sv
// Output channel: one ASCII decimal digit per item.
`default_nettype none
interface b2d_out_if;
	logic                          valid;
	logic                          ready;
	logic [b2d_pkg::CharW-1:0]     digit_char;
	logic                          last_digit;
	modport source (output valid, output digit_char, output last_digit, input ready);
	modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface
`default_nettype wire

// File: rtl/core/b2d_dabble_stage.sv
// One shift-add-3 step of the double-dabble conversion, registered.
`default_nettype none
module b2d_dabble_stage #(
	parameter int VALUE_BITS = b2d_pkg::ValueBitsDefault,
	parameter int BCD_DIGITS = 21
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      v_in,
	input  wire logic [BCD_DIGITS*4-1:0]   bcd_in,
	input  wire logic [VALUE_BITS-1:0]     bin_in,
	output logic                           v_q,
	output logic [BCD_DIGITS*4-1:0]        bcd_q,
	output logic [VALUE_BITS-1:0]          bin_q
);
	localparam int BcdW = BCD_DIGITS * 4;

	logic [BcdW-1:0] adj;

	// correct every digit, then shift in the next binary bit
	always_comb begin
		for (int d = 0; d < BCD_DIGITS; d++) begin
			adj[d*4 +: 4] = b2d_pkg::dabble_adj(bcd_in[d*4 +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bcd_q <= {adj[BcdW-2:0], bin_in[VALUE_BITS-1]};
			bin_q <= {bin_in[VALUE_BITS-2:0], 1'b0};
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/b2d_emit.sv
// Digit emitter: skips leading zeros and sends the digits out one item at a time.
`default_nettype none
module b2d_emit #(
	parameter int MAX_DIGITS = b2d_pkg::MaxDigitsDefault,
	parameter int BCD_DIGITS = 21
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    v_in,
	input  wire logic [BCD_DIGITS*4-1:0] bcd_in,
	output logic                         take,
	b2d_out_if.source                    out_ch
);
	localparam int DigW = MAX_DIGITS * 4;
	localparam int RemW = $clog2(MAX_DIGITS + 1);

	logic              busy_q;
	logic              skip_q;
	logic [DigW-1:0]   dig_q;
	logic [RemW-1:0]   rem_q;
	logic              ov_q;
	logic [b2d_pkg::CharW-1:0] ochar_q;
	logic              olast_q;
	logic [DigW-1:0]   load_dig;
	logic [3:0]        top;
	logic              out_free;
	logic              skip_now;
	logic              fire;

	// keep the low digits, padding with zeros when BCD_DIGITS is below MAX_DIGITS
	always_comb begin
		for (int k = 0; k < MAX_DIGITS; k++) begin
			if (k < BCD_DIGITS) begin
				load_dig[k*4 +: 4] = bcd_in[k*4 +: 4];
			end else begin
				load_dig[k*4 +: 4] = 4'd0;
			end
		end
	end

	assign top      = dig_q[DigW-1 -: 4];
	assign out_free = !ov_q || out_ch.ready;
	assign take     = v_in && !busy_q;
	assign skip_now = busy_q && skip_q && (top == 4'd0) && (rem_q != RemW'(1));
	assign fire     = busy_q && !skip_now && out_free;

	// digit sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			skip_q <= 1'b0;
			rem_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			skip_q <= 1'b1;
			rem_q  <= RemW'(MAX_DIGITS);
		end else if (skip_now) begin
			rem_q <= rem_q - RemW'(1);
		end else if (fire) begin
			skip_q <= 1'b0;
			rem_q  <= rem_q - RemW'(1);
			if (rem_q == RemW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dig_q <= load_dig;
		end else if (skip_now || fire) begin
			dig_q <= {dig_q[DigW-5:0], 4'd0};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (fire) begin
			ov_q <= 1'b1;
		end else if (out_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ochar_q <= b2d_pkg::AsciiZero + {2'b00, top};
			olast_q <= (rem_q == RemW'(1));
		end
	end

	assign out_ch.valid      = ov_q;
	assign out_ch.digit_char = ochar_q;
	assign out_ch.last_digit = olast_q;

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (ochar_q >= 6'd48 && ochar_q <= 6'd57))
		else $error("digit out of range");
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q != '0)
		else $error("busy with no digits left");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && rem_q == RemW'(1)) |=> !busy_q)
		else $error("run did not end after last digit");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !busy_q)
		else $error("load while busy");
endmodule
`default_nettype wire

// File: rtl/core/binary_to_decimal_digits.sv
// Top level of the binary to decimal digit converter.
//  channel | dir | payload                    | role
//  in_ch   | in  | value[63:0]                | number to convert
//  out_ch  | out | digit_char[5:0], last_digit| ASCII digits, MS first
// Conversion runs through VALUE_BITS register stages, one shift-add-3 each.
// An accepted item passes through every stage register before the emitter.
// The emitter loads it, then steps through MAX_DIGITS digit positions,
// skipping leading zeros and sending the rest, before it takes another.
// Reset clears all valid bits; a stall on out_ch holds the emitter and
// backs up the stage pipeline without losing an item.
`default_nettype none
module binary_to_decimal_digits #(
	parameter int VALUE_BITS = b2d_pkg::ValueBitsDefault,
	parameter int MAX_DIGITS = b2d_pkg::MaxDigitsDefault
) (
	input wire logic  clk,
	input wire logic  arst_n,
	b2d_in_if.sink    in_ch,
	b2d_out_if.source out_ch
);
	localparam int BcdDigits = (VALUE_BITS * 3) / 10 + 2;
	localparam int BcdW      = BcdDigits * 4;

	logic                  v_s  [VALUE_BITS+1];
	logic [BcdW-1:0]       bcd_s[VALUE_BITS+1];
	logic [VALUE_BITS-1:0] bin_s[VALUE_BITS+1];
	logic                  en_s [VALUE_BITS+1];
	logic                  take;

	assign v_s[0]   = in_ch.valid;
	assign bcd_s[0] = '0;
	assign bin_s[0] = in_ch.value[VALUE_BITS-1:0];
	assign in_ch.ready = en_s[0];

	// stall chain: a stage moves when it is empty or its successor moves
	assign en_s[VALUE_BITS] = take;
	genvar i;
	generate
		for (i = 0; i < VALUE_BITS; i++) begin : g_dabble
			assign en_s[i] = !v_s[i+1] || en_s[i+1];
			b2d_dabble_stage #(
				.VALUE_BITS(VALUE_BITS),
				.BCD_DIGITS(BcdDigits)
			) u_stage (
				.clk   (clk),
				.arst_n(arst_n),
				.en    (en_s[i]),
				.v_in  (v_s[i]),
				.bcd_in(bcd_s[i]),
				.bin_in(bin_s[i]),
				.v_q   (v_s[i+1]),
				.bcd_q (bcd_s[i+1]),
				.bin_q (bin_s[i+1])
			);
		end
	endgenerate

	b2d_emit #(
		.MAX_DIGITS(MAX_DIGITS),
		.BCD_DIGITS(BcdDigits)
	) u_emit (
		.clk   (clk),
		.arst_n(arst_n),
		.v_in  (v_s[VALUE_BITS]),
		.bcd_in(bcd_s[VALUE_BITS]),
		.take  (take),
		.out_ch(out_ch)
	);
endmodule
`default_nettype wire
